// ----- src/sipq_pkg.sv -----
// sipq_pkg: shared types, codes and defaults of the sorted insertion priority queue
// no dependencies; used by the interfaces, the cell and the top level

package sipq_pkg;

   localparam int SIPQ_DEPTH = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DUMP   = 1'b1;

   localparam logic [1:0] STATUS_INSERTED   = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_DUMP_ENTRY = 2'd2;
   localparam logic [1:0] STATUS_DUMP_EMPTY = 2'd3;

   typedef struct packed {
      logic        command;
      logic [15:0] tag;
      logic [7:0]  first_score;
      logic [7:0]  second_score;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_tag;
      logic [7:0]  out_first;
      logic [7:0]  out_second;
      logic [2:0]  position;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  first;
      logic [7:0]  second;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      rotate;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

// ----- src/sipq_req_if.sv -----
// sipq_req_if: valid/ready channel carrying one request word
// depends on sipq_pkg

interface sipq_req_if import sipq_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- src/sipq_rsp_if.sv -----
// sipq_rsp_if: valid/ready channel carrying one response word
// depends on sipq_pkg

interface sipq_rsp_if import sipq_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- src/sipq_cell.sv -----
// sipq_cell: one queue slot; compares the incoming key, shifts right on insert,
// rotates left during a dump; depends on sipq_pkg

module sipq_cell import sipq_pkg::*; #(
   parameter int DEPTH = SIPQ_DEPTH,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  cell_ctrl_type                ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   input  entry_type                    left_entry,
   input  logic                         left_keep,
   input  entry_type                    right_entry,
   input  entry_type                    head_entry,
   output entry_type                    entry,
   output logic                         keep,
   output logic                         land
);

   localparam int OW = $clog2(DEPTH + 1);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      ahead;
   logic      at_tail;

   assign occupied = OW'(INDEX) < count;
   assign ahead    = {ctrl.new_entry.first, ctrl.new_entry.second}
                     > {entry_ff.first, entry_ff.second};
   assign keep     = occupied && !ahead;
   assign land     = ctrl.insert && !keep && left_keep;
   assign at_tail  = OW'(INDEX + 1) == count;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert && !keep) begin
         entry_in = left_keep ? ctrl.new_entry : left_entry;
      end else if (ctrl.rotate) begin
         entry_in = at_tail ? head_entry : right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- src/sorted_insert_priority_queue_unit.sv -----
// sorted_insert_priority_queue_unit: insert result registered in the cycle after accept, one
// insert per cycle while results are taken; dump: the state register enters ST_DUMP, then one
// entry per cycle while entries are taken; no request is taken until the last entry is loaded
// reset (synchronous) empties the queue and the response register; slot contents are not cleared
// depends on sipq_pkg, sipq_req_if, sipq_rsp_if, sipq_cell

module sorted_insert_priority_queue_unit import sipq_pkg::*; #(
   parameter int DEPTH = SIPQ_DEPTH
) (
   input logic        clock,
   input logic        reset,
   sipq_req_if.sink   req_chan,
   sipq_rsp_if.source rsp_chan
);

   localparam int OW = $clog2(DEPTH + 1);
   localparam int CW = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [OW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   cell_ctrl_type   ctrl;
   entry_type       cell_entry [DEPTH];
   logic [DEPTH-1:0] cell_keep;
   logic [DEPTH-1:0] cell_land;
   logic [CW-1:0]   land_pos;

   logic out_free, accept, full, dump_step, dump_last;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_chan.valid && req_chan.ready;
   assign full      = count_ff == OW'(DEPTH);
   assign dump_step = (state_ff == ST_DUMP) && out_free;
   assign dump_last = (OW'(idx_ff) + OW'(1)) == count_ff;

   assign ctrl.insert    = accept && (req_chan.word.command == CMD_INSERT) && !full;
   assign ctrl.rotate    = dump_step;
   assign ctrl.new_entry = '{tag:    req_chan.word.tag,
                             first:  req_chan.word.first_score,
                             second: req_chan.word.second_score};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sipq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  ((i == 0) ? cell_entry[0] : cell_entry[(i == 0) ? 0 : i - 1]),
         .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
         .right_entry ((i == DEPTH - 1) ? cell_entry[0]
                                        : cell_entry[(i == DEPTH - 1) ? 0 : i + 1]),
         .head_entry  (cell_entry[0]),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i]),
         .land        (cell_land[i])
      );
   end

   always_comb begin
      land_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_land[i]) begin
            land_pos = land_pos | CW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               rsp_word_in.last = 1'b1;
               if (req_chan.word.command == CMD_INSERT) begin
                  if (full) begin
                     rsp_word_in.status = STATUS_FULL;
                  end else begin
                     rsp_word_in.status   = STATUS_INSERTED;
                     rsp_word_in.position = 3'(land_pos);
                     count_in = count_ff + OW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_word_in.status = STATUS_DUMP_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  idx_in   = '0;
                  state_in = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            if (dump_step) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status:     STATUS_DUMP_ENTRY,
                                out_tag:    cell_entry[0].tag,
                                out_first:  cell_entry[0].first,
                                out_second: cell_entry[0].second,
                                position:   3'(idx_ff),
                                last:       dump_last};
               idx_in = idx_ff + CW'(1);
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OW'(DEPTH))
      else $error("occupancy above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + OW'(1))
      else $error("insert did not grow occupancy");

   a_dump_holds_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |=> count_ff == $past(count_ff))
      else $error("occupancy changed during dump");

   a_dump_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> OW'(idx_ff) < count_ff)
      else $error("dump index past occupancy");

   a_land_onehot: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |-> $onehot(cell_land))
      else $error("insert landed in more than one slot");
`endif

endmodule

// ----- sim/sorted_insert_priority_queue_unit_tb.sv -----
`timescale 1ns / 100ps
// sorted_insert_priority_queue_unit_tb: directed and random insert/dump words checked against
// a behavioral sorted queue, with random idling of requests and back-pressure on responses
// depends on sipq_pkg, sipq_req_if, sipq_rsp_if and sorted_insert_priority_queue_unit

module sorted_insert_priority_queue_unit_tb;
   import sipq_pkg::*;

   localparam int RANDOM_WORDS  = 415;
   localparam int DIRECTED_ROWS = 15;
   localparam int LONG_STALL    = 200;
   localparam int DRAIN_CYCLES  = SIPQ_DEPTH + 8;

   typedef struct packed {
      req_word_type stim;
      logic         typed;
      rsp_word_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sipq_req_if req_chan ();
   sipq_rsp_if rsp_chan ();

   entry_type    queue_entries [SIPQ_DEPTH];
   int           queue_fill = 0;
   rsp_word_type pending_results [$];
   int           error_count = 0;
   int           long_holds_asked = 0;
   int           long_holds_served = 0;
   int           rsp_stall_left = 0;
   int           rsp_cycle = 0;

   // typed expectations only where they are obvious: empty dump, first slots, full queue
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{CMD_DUMP,   16'h0000, 8'h00, 8'h00}, 1'b1,
        '{STATUS_DUMP_EMPTY, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1}},
      '{'{CMD_INSERT, 16'h0000, 8'h00, 8'h00}, 1'b1,
        '{STATUS_INSERTED, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1}},
      '{'{CMD_INSERT, 16'hffff, 8'hff, 8'hff}, 1'b1,
        '{STATUS_INSERTED, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1}},
      '{'{CMD_INSERT, 16'h1234, 8'h80, 8'h80}, 1'b0, '0},
      '{'{CMD_INSERT, 16'h5678, 8'h80, 8'h80}, 1'b0, '0},
      '{'{CMD_INSERT, 16'h9abc, 8'h80, 8'h81}, 1'b0, '0},
      '{'{CMD_INSERT, 16'h0f0f, 8'h80, 8'h7f}, 1'b0, '0},
      '{'{CMD_DUMP,   16'hffff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{CMD_INSERT, 16'ha5a5, 8'hff, 8'h00}, 1'b0, '0},
      '{'{CMD_INSERT, 16'h5a5a, 8'h00, 8'hff}, 1'b0, '0},
      '{'{CMD_INSERT, 16'hffff, 8'hff, 8'hff}, 1'b1,
        '{STATUS_FULL, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1}},
      '{'{CMD_INSERT, 16'h0000, 8'h00, 8'h00}, 1'b1,
        '{STATUS_FULL, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1}},
      '{'{CMD_DUMP,   16'h0000, 8'h00, 8'h00}, 1'b0, '0},
      '{'{CMD_DUMP,   16'h8001, 8'h7e, 8'h81}, 1'b0, '0},
      '{'{CMD_INSERT, 16'h8000, 8'h01, 8'hfe}, 1'b1,
        '{STATUS_FULL, 16'h0000, 8'h00, 8'h00, 3'd0, 1'b1}}
   };

   sorted_insert_priority_queue_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   function automatic rsp_word_type make_rsp(logic [1:0] status, logic [15:0] tag,
                                             logic [7:0] first, logic [7:0] second,
                                             logic [2:0] position, logic last);
      return {status, tag, first, second, position, last};
   endfunction

   function automatic void predict_queue_response(req_word_type w);
      int slot;
      if (w.command == CMD_INSERT) begin
         if (queue_fill >= SIPQ_DEPTH) begin
            pending_results.push_back(make_rsp(STATUS_FULL, '0, '0, '0, '0, 1'b1));
         end else begin
            // equal keys stay behind the ones already queued
            slot = queue_fill;
            while (slot > 0 && {w.first_score, w.second_score} >
                   {queue_entries[slot - 1].first, queue_entries[slot - 1].second}) begin
               queue_entries[slot] = queue_entries[slot - 1];
               slot--;
            end
            queue_entries[slot] = '{w.tag, w.first_score, w.second_score};
            queue_fill++;
            pending_results.push_back(make_rsp(STATUS_INSERTED, '0, '0, '0, 3'(slot), 1'b1));
         end
      end else if (queue_fill == 0) begin
         pending_results.push_back(make_rsp(STATUS_DUMP_EMPTY, '0, '0, '0, '0, 1'b1));
      end else begin
         for (int i = 0; i < queue_fill; i++) begin
            pending_results.push_back(make_rsp(STATUS_DUMP_ENTRY, queue_entries[i].tag,
                                               queue_entries[i].first,
                                               queue_entries[i].second, 3'(i),
                                               i == queue_fill - 1));
         end
      end
   endfunction

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 8);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 30) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endtask

   // one request word: offer, wait for accept, predict, then idle if asked
   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type want, input int gap);
      req_chan.valid <= 1'b1;
      req_chan.word  <= w;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      predict_queue_response(w);
      if (typed) begin
         void'(pending_results.pop_back());
         pending_results.push_back(want);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      req_word_type w;
      req_chan.valid = 1'b0;
      req_chan.word  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_word(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want,
                   idle_gap());
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 100) begin
            long_holds_asked++;
         end
         if (n == 250) begin
            // sender pause until the queue of expectations is drained
            req_chan.valid <= 1'b0;
            while (pending_results.size() != 0) begin
               @(posedge clock);
            end
         end
         w.command      = ($urandom_range(99) < 35) ? CMD_DUMP : CMD_INSERT;
         w.tag          = 16'($urandom);
         w.first_score  = 8'($urandom);
         w.second_score = 8'($urandom);
         send_word(w, 1'b0, '0, (n % 80 < 16) ? 0 : idle_gap());
      end
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("sorted_insert_priority_queue_unit_tb OK");
      end else begin
         $display("sorted_insert_priority_queue_unit_tb NOT OK");
      end
      $finish;
   end

   initial rsp_chan.ready = 1'b0;

   // response pacing: random stalls, steady windows and one long hold
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         take = 1'b0;
      end else if (long_holds_served != long_holds_asked) begin
         long_holds_served++;
         rsp_stall_left = LONG_STALL;
         take = 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         take = 1'b0;
      end else if (rsp_chan.valid === 1'b1 && rsp_chan.ready && rsp_cycle % 1500 >= 300) begin
         rsp_stall_left = idle_gap();
         take = (rsp_stall_left == 0);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
         end
      end else begin
         take = 1'b1;
      end
      rsp_cycle++;
      rsp_chan.ready <= take;
   end

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = rsp_chan.word;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word status %0d tag %h", got.status,
                                      got.out_tag));
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.out_tag !== want.out_tag) begin
               report_mismatch($sformatf("out_tag %h, want %h", got.out_tag, want.out_tag));
            end
            if (got.out_first !== want.out_first) begin
               report_mismatch($sformatf("out_first %h, want %h", got.out_first,
                                         want.out_first));
            end
            if (got.out_second !== want.out_second) begin
               report_mismatch($sformatf("out_second %h, want %h", got.out_second,
                                         want.out_second));
            end
            if (got.position !== want.position) begin
               report_mismatch($sformatf("position %0d, want %0d", got.position,
                                         want.position));
            end
            if (got.last !== want.last) begin
               report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("sorted_insert_priority_queue_unit_tb NOT OK");
      $finish;
   end

endmodule
